/* rtl/core/whp_pkg.sv */
// Package: types and constants shared by the wave header parser files.
package whp_pkg;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [31:0] MAX_RATE_RESET = 32'd48000;
    localparam logic [31:0] FMT_LEN_STD    = 32'd16;
    localparam logic [31:0] FMT_LEN_EXT    = 32'd18;
    localparam logic [15:0] PCM_FORMAT     = 16'd1;
    localparam logic [15:0] MAX_CHANNELS   = 16'd2;
    localparam logic [15:0] BITS_8         = 16'd8;
    localparam logic [15:0] BITS_16        = 16'd16;

    typedef enum logic [3:0] {
        PH_RIFF,
        PH_RIFFSIZE,
        PH_WAVE,
        PH_FMT,
        PH_FMTSIZE,
        PH_FMTBODY,
        PH_CHUNKID,
        PH_CHUNKSZ,
        PH_SKIP,
        PH_PAYLOAD,
        PH_DONE,
        PH_HALT
    } t_phase;

    typedef enum logic [1:0] {
        KIND_FORMAT  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_ERROR   = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        ERR_NONE       = 4'd0,
        ERR_RIFF       = 4'd1,
        ERR_WAVE       = 4'd2,
        ERR_FMT        = 4'd3,
        ERR_NOT_PCM    = 4'd4,
        ERR_CHANNELS   = 4'd5,
        ERR_RATE       = 4'd6,
        ERR_BITS       = 4'd7,
        ERR_BYTE_RATE  = 4'd8,
        ERR_ALIGN      = 4'd9,
        ERR_ZERO_CHUNK = 4'd10
    } t_err;

    typedef struct packed {
        logic [15:0] format_code;
        logic [15:0] num_channels;
        logic [31:0] sample_rate;
        logic [31:0] byte_rate;
        logic [15:0] block_align;
        logic [15:0] bits_per_sample;
    } t_fmt;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] num_channels;
        logic [31:0] sample_rate;
        logic [31:0] byte_rate;
        logic [15:0] block_align;
        logic [15:0] bits_per_sample;
        logic [31:0] data_length;
        t_err        error_code;
        logic        fmt_size_warning;
        logic [7:0]  payload_byte;
        logic        last_payload;
    } t_result;

endpackage

/* rtl/core/whp_if.sv */
// Interfaces: byte input channel, result channel and configuration write channel.
interface whp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       start_of_file;

    modport source (output valid, output byte_value, output start_of_file, input ready);
    modport sink   (input valid, input byte_value, input start_of_file, output ready);
endinterface

interface whp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] num_channels;
    logic [31:0] sample_rate;
    logic [31:0] byte_rate;
    logic [15:0] block_align;
    logic [15:0] bits_per_sample;
    logic [31:0] data_length;
    logic [3:0]  error_code;
    logic        fmt_size_warning;
    logic [7:0]  payload_byte;
    logic        last_payload;

    modport source (
        output valid, output kind, output num_channels, output sample_rate,
        output byte_rate, output block_align, output bits_per_sample,
        output data_length, output error_code, output fmt_size_warning,
        output payload_byte, output last_payload, input ready
    );
    modport sink (
        input valid, input kind, input num_channels, input sample_rate,
        input byte_rate, input block_align, input bits_per_sample,
        input data_length, input error_code, input fmt_size_warning,
        input payload_byte, input last_payload, output ready
    );
endinterface

interface whp_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/whp_fmt_check.sv */
// Format check: validates captured fmt fields and returns the first failing error code.
module whp_fmt_check (
    input  whp_pkg::t_fmt   i_fmt,
    input  logic [31:0]     i_max_sample_rate,
    output whp_pkg::t_err   o_err_code
);
    import whp_pkg::*;

    logic        wide;
    logic [2:0]  frame;
    logic [31:0] expect_rate;

    always_comb begin
        wide  = (i_fmt.bits_per_sample == BITS_16);
        frame = wide ? {i_fmt.num_channels[1:0], 1'b0} : {1'b0, i_fmt.num_channels[1:0]};
        case (frame)
            3'd1:    expect_rate = i_fmt.sample_rate;
            3'd2:    expect_rate = {i_fmt.sample_rate[30:0], 1'b0};
            3'd4:    expect_rate = {i_fmt.sample_rate[29:0], 2'b00};
            default: expect_rate = '0;
        endcase

        if (i_fmt.format_code != PCM_FORMAT) begin
            o_err_code = ERR_NOT_PCM;
        end else if (i_fmt.num_channels > MAX_CHANNELS) begin
            o_err_code = ERR_CHANNELS;
        end else if (i_fmt.sample_rate > i_max_sample_rate) begin
            o_err_code = ERR_RATE;
        end else if (i_fmt.bits_per_sample != BITS_8 && !wide) begin
            o_err_code = ERR_BITS;
        end else if (i_fmt.byte_rate != expect_rate) begin
            o_err_code = ERR_BYTE_RATE;
        end else if (i_fmt.block_align != {13'd0, frame}) begin
            o_err_code = ERR_ALIGN;
        end else begin
            o_err_code = ERR_NONE;
        end
    end

endmodule

/* rtl/core/wave_header_parser_core.sv */
// Top level: RIFF/WAVE PCM header parser with format, payload and error items.
// One file byte is taken per cycle and its result item, if any, appears in the
// output register on the following cycle. The parse state and all field capture
// and format checks are updated together from each accepted byte, so the
// sustained rate is one byte per cycle; i_in.ready falls only while the output
// register holds an item that the sink has not taken. A byte with start_of_file
// set restarts parsing at that byte. After an error item or the end of the data
// chunk, bytes give no item until the next start of file. The max sample rate
// register resets to 48000 and is written through i_cfg at any time (always ready).
module wave_header_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    whp_in_if.sink      i_in,
    whp_out_if.source   o_out,
    whp_cfg_if.sink     i_cfg
);
    import whp_pkg::*;

    t_phase      r_phase, n_phase;
    logic [31:0] r_section_count, n_section_count;
    logic [31:0] r_tag_shift, n_tag_shift;
    logic [31:0] r_fmt_length, n_fmt_length;
    t_fmt        r_fmt, n_fmt;
    logic [31:0] r_chunk_length, n_chunk_length;
    logic        r_first_after_fmt, n_first_after_fmt;
    logic [31:0] r_max_sample_rate;
    logic        r_out_valid;
    t_result     r_result;

    t_phase      cur_phase;
    logic [31:0] cur_count;
    logic [31:0] cur_tag;
    logic [31:0] cur_fmt_length;
    t_fmt        cur_fmt;
    t_fmt        cap_fmt;
    logic [31:0] cur_chunk;
    logic        cur_first;
    logic [31:0] count_inc;
    logic [7:0]  b;
    t_err        chk_err;
    logic        in_accept;
    logic        res_valid;
    t_result     res;

    assign in_accept   = i_in.valid && i_in.ready;
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign i_cfg.ready = 1'b1;
    assign b           = i_in.byte_value;

    // restart view of the state
    always_comb begin
        if (i_in.start_of_file) begin
            cur_phase      = PH_RIFF;
            cur_count      = '0;
            cur_tag        = '0;
            cur_fmt_length = '0;
            cur_fmt        = '0;
            cur_chunk      = '0;
            cur_first      = 1'b1;
        end else begin
            cur_phase      = r_phase;
            cur_count      = r_section_count;
            cur_tag        = r_tag_shift;
            cur_fmt_length = r_fmt_length;
            cur_fmt        = r_fmt;
            cur_chunk      = r_chunk_length;
            cur_first      = r_first_after_fmt;
        end
        count_inc = cur_count + 32'd1;
    end

    // fmt body field capture
    always_comb begin
        cap_fmt = cur_fmt;
        if (cur_phase == PH_FMTBODY && cur_count[31:4] == '0) begin
            case (cur_count[3:0])
                4'd0:    cap_fmt.format_code[7:0]      = cur_fmt.format_code[7:0] | b;
                4'd1:    cap_fmt.format_code[15:8]     = cur_fmt.format_code[15:8] | b;
                4'd2:    cap_fmt.num_channels[7:0]     = cur_fmt.num_channels[7:0] | b;
                4'd3:    cap_fmt.num_channels[15:8]    = cur_fmt.num_channels[15:8] | b;
                4'd4:    cap_fmt.sample_rate[7:0]      = cur_fmt.sample_rate[7:0] | b;
                4'd5:    cap_fmt.sample_rate[15:8]     = cur_fmt.sample_rate[15:8] | b;
                4'd6:    cap_fmt.sample_rate[23:16]    = cur_fmt.sample_rate[23:16] | b;
                4'd7:    cap_fmt.sample_rate[31:24]    = cur_fmt.sample_rate[31:24] | b;
                4'd8:    cap_fmt.byte_rate[7:0]        = cur_fmt.byte_rate[7:0] | b;
                4'd9:    cap_fmt.byte_rate[15:8]       = cur_fmt.byte_rate[15:8] | b;
                4'd10:   cap_fmt.byte_rate[23:16]      = cur_fmt.byte_rate[23:16] | b;
                4'd11:   cap_fmt.byte_rate[31:24]      = cur_fmt.byte_rate[31:24] | b;
                4'd12:   cap_fmt.block_align[7:0]      = cur_fmt.block_align[7:0] | b;
                4'd13:   cap_fmt.block_align[15:8]     = cur_fmt.block_align[15:8] | b;
                4'd14:   cap_fmt.bits_per_sample[7:0]  = cur_fmt.bits_per_sample[7:0] | b;
                4'd15:   cap_fmt.bits_per_sample[15:8] = cur_fmt.bits_per_sample[15:8] | b;
                default: cap_fmt = cur_fmt;
            endcase
        end
    end

    whp_fmt_check u_fmt_check (
        .i_fmt             (cap_fmt),
        .i_max_sample_rate (r_max_sample_rate),
        .o_err_code        (chk_err)
    );

    // next state and result
    always_comb begin
        n_phase           = cur_phase;
        n_section_count   = cur_count;
        n_tag_shift       = cur_tag;
        n_fmt_length      = cur_fmt_length;
        n_fmt             = cap_fmt;
        n_chunk_length    = cur_chunk;
        n_first_after_fmt = cur_first;
        res_valid         = 1'b0;
        res               = '0;

        case (cur_phase)
            PH_RIFF, PH_WAVE, PH_FMT, PH_CHUNKID: begin
                n_tag_shift = {b, cur_tag[31:8]};
                if (cur_count[1:0] != 2'd3) begin
                    n_section_count = count_inc;
                end else begin
                    n_section_count = '0;
                    case (cur_phase)
                        PH_RIFF: begin
                            if (n_tag_shift != TAG_RIFF) begin
                                res_valid      = 1'b1;
                                res.kind       = KIND_ERROR;
                                res.error_code = ERR_RIFF;
                                n_phase        = PH_HALT;
                            end else begin
                                n_phase = PH_RIFFSIZE;
                            end
                        end
                        PH_WAVE: begin
                            if (n_tag_shift != TAG_WAVE) begin
                                res_valid      = 1'b1;
                                res.kind       = KIND_ERROR;
                                res.error_code = ERR_WAVE;
                                n_phase        = PH_HALT;
                            end else begin
                                n_phase = PH_FMT;
                            end
                        end
                        PH_FMT: begin
                            if (n_tag_shift != TAG_FMT) begin
                                res_valid      = 1'b1;
                                res.kind       = KIND_ERROR;
                                res.error_code = ERR_FMT;
                                n_phase        = PH_HALT;
                            end else begin
                                n_phase = PH_FMTSIZE;
                            end
                        end
                        default: begin
                            n_chunk_length = '0;
                            n_phase        = PH_CHUNKSZ;
                        end
                    endcase
                end
            end
            PH_RIFFSIZE: begin
                if (cur_count[1:0] != 2'd3) begin
                    n_section_count = count_inc;
                end else begin
                    n_section_count = '0;
                    n_phase         = PH_WAVE;
                end
            end
            PH_FMTSIZE: begin
                n_fmt_length = {b, cur_fmt_length[31:8]};
                if (cur_count[1:0] != 2'd3) begin
                    n_section_count = count_inc;
                end else begin
                    n_section_count = '0;
                    if (n_fmt_length != '0) begin
                        n_phase = PH_FMTBODY;
                    end else if (chk_err != ERR_NONE) begin
                        res_valid      = 1'b1;
                        res.kind       = KIND_ERROR;
                        res.error_code = chk_err;
                        n_phase        = PH_HALT;
                    end else begin
                        n_phase = PH_CHUNKID;
                    end
                end
            end
            PH_FMTBODY: begin
                n_section_count = count_inc;
                if (count_inc == cur_fmt_length) begin
                    if (chk_err != ERR_NONE) begin
                        res_valid      = 1'b1;
                        res.kind       = KIND_ERROR;
                        res.error_code = chk_err;
                        n_phase        = PH_HALT;
                    end else begin
                        n_section_count = '0;
                        n_phase         = PH_CHUNKID;
                    end
                end
            end
            PH_CHUNKSZ: begin
                n_chunk_length = {b, cur_chunk[31:8]};
                if (cur_count[1:0] != 2'd3) begin
                    n_section_count = count_inc;
                end else begin
                    n_section_count   = '0;
                    n_first_after_fmt = 1'b0;
                    if (!cur_first && n_chunk_length == '0) begin
                        res_valid      = 1'b1;
                        res.kind       = KIND_ERROR;
                        res.error_code = ERR_ZERO_CHUNK;
                        n_phase        = PH_HALT;
                    end else if (cur_tag == TAG_DATA) begin
                        res_valid            = 1'b1;
                        res.kind             = KIND_FORMAT;
                        res.num_channels     = cur_fmt.num_channels;
                        res.sample_rate      = cur_fmt.sample_rate;
                        res.byte_rate        = cur_fmt.byte_rate;
                        res.block_align      = cur_fmt.block_align;
                        res.bits_per_sample  = cur_fmt.bits_per_sample;
                        res.data_length      = n_chunk_length;
                        res.fmt_size_warning = (cur_fmt_length != FMT_LEN_STD)
                                            && (cur_fmt_length != FMT_LEN_EXT);
                        n_phase = (n_chunk_length != '0) ? PH_PAYLOAD : PH_DONE;
                    end else begin
                        n_phase = (n_chunk_length != '0) ? PH_SKIP : PH_CHUNKID;
                    end
                end
            end
            PH_SKIP: begin
                n_chunk_length = cur_chunk - 32'd1;
                if (cur_chunk == 32'd1) begin
                    n_phase = PH_CHUNKID;
                end
            end
            PH_PAYLOAD: begin
                res_valid        = 1'b1;
                res.kind         = KIND_PAYLOAD;
                res.payload_byte = b;
                res.last_payload = (cur_chunk == 32'd1);
                n_chunk_length   = cur_chunk - 32'd1;
                if (cur_chunk == 32'd1) begin
                    n_phase = PH_DONE;
                end
            end
            default: begin
                n_phase = cur_phase;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase           <= PH_RIFF;
            r_section_count   <= '0;
            r_tag_shift       <= '0;
            r_fmt_length      <= '0;
            r_fmt             <= '0;
            r_chunk_length    <= '0;
            r_first_after_fmt <= 1'b1;
        end else if (in_accept) begin
            r_phase           <= n_phase;
            r_section_count   <= n_section_count;
            r_tag_shift       <= n_tag_shift;
            r_fmt_length      <= n_fmt_length;
            r_fmt             <= n_fmt;
            r_chunk_length    <= n_chunk_length;
            r_first_after_fmt <= n_first_after_fmt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_sample_rate <= MAX_RATE_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_max_sample_rate <= i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= res_valid;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && res_valid) begin
            r_result <= res;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.kind             = r_result.kind;
    assign o_out.num_channels     = r_result.num_channels;
    assign o_out.sample_rate      = r_result.sample_rate;
    assign o_out.byte_rate        = r_result.byte_rate;
    assign o_out.block_align      = r_result.block_align;
    assign o_out.bits_per_sample  = r_result.bits_per_sample;
    assign o_out.data_length      = r_result.data_length;
    assign o_out.error_code       = r_result.error_code;
    assign o_out.fmt_size_warning = r_result.fmt_size_warning;
    assign o_out.payload_byte     = r_result.payload_byte;
    assign o_out.last_payload     = r_result.last_payload;

    a_quiet_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && !i_in.start_of_file && (r_phase == PH_HALT || r_phase == PH_DONE))
        |-> !res_valid)
        else $error("item produced after halt or end of data");

    a_last_ends_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && res_valid && res.last_payload) |=> (r_phase == PH_DONE))
        else $error("last payload byte did not end the data chunk");

    a_error_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && res_valid && res.kind == KIND_ERROR) |=> (r_phase == PH_HALT))
        else $error("error item without halt");

    a_count_small: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_FMTBODY && r_phase != PH_HALT) |-> (r_section_count < 32'd4))
        else $error("section count out of range");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> (r_out_valid && $stable(r_result)))
        else $error("stalled item lost");

endmodule

/* test/whp_checker.sv */
// Checker: watches the wave header parser channels, predicts each result item and compares.
module whp_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    whp_in_if    i_in_ch,
    whp_out_if   i_out_ch,
    whp_cfg_if   i_cfg_ch,
    output int   o_fail_count,
    output int   o_pending
);
    import whp_pkg::*;

    t_phase      phase;
    logic [31:0] count;
    logic [31:0] tag_sr;
    logic [31:0] fmt_len;
    logic [15:0] fmt_code;
    logic [15:0] chans;
    logic [31:0] rate;
    logic [31:0] brate;
    logic [15:0] align;
    logic [15:0] bits;
    logic [31:0] chunk_len;
    logic        first_chunk;
    logic [31:0] max_rate;
    t_result     expected_items[$];

    task automatic clear_parse_state();
        phase       = PH_RIFF;
        count       = '0;
        tag_sr      = '0;
        fmt_len     = '0;
        fmt_code    = '0;
        chans       = '0;
        rate        = '0;
        brate       = '0;
        align       = '0;
        bits        = '0;
        chunk_len   = '0;
        first_chunk = 1'b1;
    endtask

    function automatic t_err format_verdict();
        logic [31:0] frame;
        if (fmt_code != PCM_FORMAT) return ERR_NOT_PCM;
        if (chans > MAX_CHANNELS) return ERR_CHANNELS;
        if (rate > max_rate) return ERR_RATE;
        if (bits != BITS_8 && bits != BITS_16) return ERR_BITS;
        frame = (bits == BITS_16) ? {15'b0, chans, 1'b0} : {16'b0, chans};
        if (brate != rate * frame) return ERR_BYTE_RATE;
        if ({16'b0, align} != frame) return ERR_ALIGN;
        return ERR_NONE;
    endfunction

    task automatic capture_field(input logic [7:0] b);
        logic [31:0] b32;
        int          sh;
        b32 = {24'b0, b};
        sh  = count[0] ? 8 : 0;
        if (count < 2) fmt_code = fmt_code | 16'(b32 << sh);
        else if (count < 4) chans = chans | 16'(b32 << sh);
        else if (count < 8) rate = rate | (b32 << ((count - 4) * 8));
        else if (count < 12) brate = brate | (b32 << ((count - 8) * 8));
        else if (count < 14) align = align | 16'(b32 << sh);
        else if (count < 16) bits = bits | 16'(b32 << sh);
    endtask

    // Advances the parse by one byte; returns 1 with the item when one is due.
    task automatic parse_byte(input logic [7:0] b, input logic sof,
                              output logic emit, output t_result r);
        t_err err;
        logic fmt_done;
        logic first;
        r        = '0;
        emit     = 1'b0;
        err      = ERR_NONE;
        fmt_done = 1'b0;
        if (sof) clear_parse_state();
        case (phase)
            PH_RIFF, PH_WAVE, PH_FMT, PH_CHUNKID: begin
                tag_sr = {b, tag_sr[31:8]};
                count++;
                if (count == 4) begin
                    count = '0;
                    if (phase == PH_RIFF) begin
                        if (tag_sr != TAG_RIFF) err = ERR_RIFF;
                        else phase = PH_RIFFSIZE;
                    end else if (phase == PH_WAVE) begin
                        if (tag_sr != TAG_WAVE) err = ERR_WAVE;
                        else phase = PH_FMT;
                    end else if (phase == PH_FMT) begin
                        if (tag_sr != TAG_FMT) err = ERR_FMT;
                        else phase = PH_FMTSIZE;
                    end else begin
                        chunk_len = '0;
                        phase = PH_CHUNKSZ;
                    end
                end
            end
            PH_RIFFSIZE: begin
                count++;
                if (count >= 4) begin
                    count = '0;
                    phase = PH_WAVE;
                end
            end
            PH_FMTSIZE: begin
                fmt_len = {b, fmt_len[31:8]};
                count++;
                if (count == 4) begin
                    count = '0;
                    if (fmt_len == 0) fmt_done = 1'b1;
                    else phase = PH_FMTBODY;
                end
            end
            PH_FMTBODY: begin
                capture_field(b);
                count++;
                if (count == fmt_len) fmt_done = 1'b1;
            end
            PH_CHUNKSZ: begin
                chunk_len = {b, chunk_len[31:8]};
                count++;
                if (count == 4) begin
                    count = '0;
                    first = first_chunk;
                    first_chunk = 1'b0;
                    if (!first && chunk_len == 0) begin
                        err = ERR_ZERO_CHUNK;
                    end else if (tag_sr == TAG_DATA) begin
                        r.kind             = KIND_FORMAT;
                        r.num_channels     = chans;
                        r.sample_rate      = rate;
                        r.byte_rate        = brate;
                        r.block_align      = align;
                        r.bits_per_sample  = bits;
                        r.data_length      = chunk_len;
                        r.fmt_size_warning = (fmt_len != FMT_LEN_STD && fmt_len != FMT_LEN_EXT);
                        emit = 1'b1;
                        if (chunk_len != 0) phase = PH_PAYLOAD;
                        else phase = PH_DONE;
                    end else begin
                        if (chunk_len != 0) phase = PH_SKIP;
                        else phase = PH_CHUNKID;
                    end
                end
            end
            PH_SKIP: begin
                chunk_len--;
                if (chunk_len == 0) phase = PH_CHUNKID;
            end
            PH_PAYLOAD: begin
                r.kind         = KIND_PAYLOAD;
                r.payload_byte = b;
                r.last_payload = (chunk_len == 1);
                emit = 1'b1;
                chunk_len--;
                if (chunk_len == 0) phase = PH_DONE;
            end
            default: ;
        endcase
        if (fmt_done) begin
            err = format_verdict();
            if (err == ERR_NONE) begin
                phase = PH_CHUNKID;
                count = '0;
            end
        end
        if (err != ERR_NONE) begin
            r.kind       = KIND_ERROR;
            r.error_code = err;
            phase = PH_HALT;
            emit = 1'b1;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        t_result next_item;
        logic    emit;
        if (!i_rst_n) begin
            clear_parse_state();
            max_rate = MAX_RATE_RESET;
            expected_items.delete();
            o_fail_count = 0;
        end else begin
            if (i_out_ch.valid && i_out_ch.ready) begin
                if (expected_items.size() == 0) begin
                    $display("%0t: unexpected item, expected none actual kind %0d",
                             $time, i_out_ch.kind);
                    o_fail_count++;
                end else begin
                    want = expected_items.pop_front();
                    check_field("kind", 32'(want.kind), 32'(i_out_ch.kind));
                    check_field("num_channels", 32'(want.num_channels),
                                32'(i_out_ch.num_channels));
                    check_field("sample_rate", want.sample_rate, i_out_ch.sample_rate);
                    check_field("byte_rate", want.byte_rate, i_out_ch.byte_rate);
                    check_field("block_align", 32'(want.block_align),
                                32'(i_out_ch.block_align));
                    check_field("bits_per_sample", 32'(want.bits_per_sample),
                                32'(i_out_ch.bits_per_sample));
                    check_field("data_length", want.data_length, i_out_ch.data_length);
                    check_field("error_code", 32'(want.error_code),
                                32'(i_out_ch.error_code));
                    check_field("fmt_size_warning", 32'(want.fmt_size_warning),
                                32'(i_out_ch.fmt_size_warning));
                    check_field("payload_byte", 32'(want.payload_byte),
                                32'(i_out_ch.payload_byte));
                    check_field("last_payload", 32'(want.last_payload),
                                32'(i_out_ch.last_payload));
                end
            end
            if (i_in_ch.valid && i_in_ch.ready) begin
                parse_byte(i_in_ch.byte_value, i_in_ch.start_of_file, emit, next_item);
                if (emit) expected_items.push_back(next_item);
            end
            if (i_cfg_ch.valid && i_cfg_ch.ready) max_rate = i_cfg_ch.data;
        end
        o_pending = expected_items.size();
    end

endmodule

/* test/testbench.sv */
// Testbench top: drives WAVE byte streams and rate settings into the parser and reports the verdict.
module testbench;
    import whp_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 8;
    localparam int ITEMS_PER_SET  = 270;

    typedef enum int {
        FLAW_NONE,
        FLAW_RIFF,
        FLAW_WAVE,
        FLAW_FMT_TAG,
        FLAW_NOT_PCM,
        FLAW_CHANNELS,
        FLAW_RATE,
        FLAW_BITS,
        FLAW_BYTE_RATE,
        FLAW_ALIGN,
        FLAW_ZERO_CHUNK,
        FLAW_SHORT_FMT,
        FLAW_NOISE,
        FLAW_CUT
    } t_flaw;

    logic clk = 1'b0;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   idle_run = 0;

    logic [7:0]  file_q[$];
    int          trailer_len;
    logic [31:0] cur_max;
    bit          sender_steady;

    whp_in_if  in_ch();
    whp_out_if out_ch();
    whp_cfg_if cfg_ch();

    wave_header_parser_core u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    whp_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_ch      (in_ch),
        .i_out_ch     (out_ch),
        .i_cfg_ch     (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            idle_run <= 0;
        end else if (idle_run + 1 >= WATCHDOG_LIMIT) begin
            $display("wave_header_parser_core verification failed");
            $finish;
        end else begin
            idle_run <= idle_run + 1;
        end
    end

    // Result sink: random stalls, steady stretches, and long hold-offs to back up the input.
    initial begin
        int gap;
        int taken;
        bit steady;
        out_ch.ready = 1'b0;
        taken = 0;
        steady = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            if ($urandom_range(0, 39) == 0) steady = !steady;
            gap = steady ? 0 : $urandom_range(0, 13);
            if (taken == 20 || taken == 150) gap = HOLD_CYCLES;
            if (gap != 0) begin
                out_ch.ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ch.ready = 1'b1;
            do @(posedge clk); while (!out_ch.valid);
            taken++;
            @(negedge clk);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic sof);
        int gap;
        gap = sender_steady ? 0 : $urandom_range(0, 13);
        if (gap != 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid         = 1'b1;
        in_ch.byte_value    = b;
        in_ch.start_of_file = sof;
        do @(posedge clk); while (!in_ch.ready);
        @(negedge clk);
    endtask

    task automatic send_file();
        for (int i = 0; i < file_q.size(); i++) send_byte(file_q[i], i == 0);
    endtask

    task automatic push_word(input logic [31:0] v, input int n);
        for (int i = 0; i < n; i++) file_q.push_back(v[8*i +: 8]);
    endtask

    function automatic logic [31:0] flip_bit(input logic [31:0] v);
        return v ^ (32'h1 << $urandom_range(0, 31));
    endfunction

    // Builds one file into file_q with the given defect, if any.
    task automatic build_file(input t_flaw flaw);
        logic [15:0] fcode;
        logic [15:0] nch;
        logic [15:0] blk;
        logic [15:0] nbits;
        logic [31:0] srate;
        logic [31:0] brate_v;
        logic [31:0] frame;
        logic [31:0] fsize;
        logic [31:0] dlen;
        logic [31:0] csize;
        logic [31:0] cid;
        int          n_chunks;
        file_q.delete();
        trailer_len = 0;
        if (flaw == FLAW_NOISE) begin
            repeat ($urandom_range(1, 20)) file_q.push_back(8'($urandom));
            return;
        end
        push_word(flaw == FLAW_RIFF ? flip_bit(TAG_RIFF) : TAG_RIFF, 4);
        push_word($urandom, 4);
        push_word(flaw == FLAW_WAVE ? flip_bit(TAG_WAVE) : TAG_WAVE, 4);
        push_word(flaw == FLAW_FMT_TAG ? flip_bit(TAG_FMT) : TAG_FMT, 4);

        fcode = PCM_FORMAT;
        nch   = 16'($urandom_range(0, 2));
        nbits = $urandom_range(0, 1) ? BITS_16 : BITS_8;
        case ($urandom_range(0, 3))
            0:       srate = cur_max;
            1:       srate = 32'd44100;
            2:       srate = 32'd8000;
            default: srate = $urandom_range(0, cur_max);
        endcase
        if (srate > cur_max) srate = cur_max;
        case (flaw)
            FLAW_NOT_PCM: begin
                fcode = 16'($urandom);
                if (fcode == PCM_FORMAT) fcode = 16'd3;
            end
            FLAW_CHANNELS: nch = 16'($urandom_range(3, 65535));
            FLAW_RATE: if (cur_max != 32'hFFFF_FFFF) srate = $urandom_range(cur_max + 1, 32'hFFFF_FFFF);
            FLAW_BITS: begin
                nbits = 16'($urandom);
                if (nbits == BITS_8 || nbits == BITS_16) nbits = 16'd24;
            end
            default: ;
        endcase
        frame   = (nbits == BITS_16) ? {15'b0, nch, 1'b0} : {16'b0, nch};
        brate_v = srate * frame;
        blk     = frame[15:0];
        if (flaw == FLAW_BYTE_RATE) brate_v = flip_bit(brate_v);
        if (flaw == FLAW_ALIGN) blk = blk ^ (16'h1 << $urandom_range(0, 15));

        case ($urandom_range(0, 5))
            0, 1, 2: fsize = FMT_LEN_STD;
            3:       fsize = FMT_LEN_EXT;
            4:       fsize = $urandom_range(17, 28);
            default: fsize = $urandom_range(0, 15);
        endcase
        if (flaw == FLAW_SHORT_FMT) fsize = $urandom_range(0, 15);
        push_word(fsize, 4);
        push_word(32'(fcode), 2);
        push_word(32'(nch), 2);
        push_word(srate, 4);
        push_word(brate_v, 4);
        push_word(32'(blk), 2);
        push_word(32'(nbits), 2);
        if (fsize < 16) repeat (16 - fsize) void'(file_q.pop_back());
        else repeat (fsize - 16) file_q.push_back(8'($urandom));

        n_chunks = $urandom_range(0, 2);
        if (flaw == FLAW_ZERO_CHUNK && n_chunks == 0) n_chunks = 1;
        for (int k = 0; k < n_chunks; k++) begin
            cid = $urandom;
            if (cid == TAG_DATA) cid = ~cid;
            if ((k == 0 || flaw == FLAW_ZERO_CHUNK) && $urandom_range(0, 2) == 0) csize = 0;
            else csize = $urandom_range(1, 12);
            push_word(cid, 4);
            push_word(csize, 4);
            repeat (csize) file_q.push_back(8'($urandom));
        end

        if (flaw == FLAW_ZERO_CHUNK) dlen = 0;
        else if ($urandom_range(0, 7) == 0) dlen = 0;
        else if ($urandom_range(0, 9) == 0) dlen = $urandom_range(25, 64);
        else dlen = $urandom_range(1, 24);
        push_word(TAG_DATA, 4);
        push_word(dlen, 4);
        repeat (dlen) file_q.push_back(8'($urandom));
        if ($urandom_range(0, 3) == 0) begin
            trailer_len = $urandom_range(1, 6);
            repeat (trailer_len) file_q.push_back(8'($urandom));
        end
        if (flaw == FLAW_CUT) begin
            trailer_len = 0;
            repeat ($urandom_range(1, file_q.size() - 1)) void'(file_q.pop_back());
        end
    endtask

    task automatic write_max_rate(input logic [31:0] value);
        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.data  = value;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
        cur_max = value;
    endtask

    initial begin
        logic [31:0] settings[6];
        logic [31:0] rnd_rate;
        logic [7:0]  directed[$];
        int          counted;
        t_flaw       flaw;
        rst_n               = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.byte_value    = '0;
        in_ch.start_of_file = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.data         = '0;
        cur_max             = MAX_RATE_RESET;
        sender_steady       = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: bad RIFF tag with extreme bytes, restart mid-file, bad WAVE tag.
        directed = {8'h00, 8'hFF, 8'h00, 8'hFF,
                    8'h52, 8'h49, 8'h46, 8'h46, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                    8'h52, 8'h49, 8'h46, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00,
                    8'h57, 8'h41, 8'h56, 8'h58};
        foreach (directed[i]) send_byte(directed[i], i == 0 || i == 12);
        build_file(FLAW_NONE);
        send_file();

        rnd_rate = $urandom;
        if (rnd_rate == 0) rnd_rate = 1;
        settings = '{MAX_RATE_RESET, 32'd1, 32'hFFFF_FFFF, 32'd44100, 32'd96000, rnd_rate};
        foreach (settings[s]) begin
            if (s != 0) write_max_rate(settings[s]);
            counted = 0;
            while (counted < ITEMS_PER_SET) begin
                if ($urandom_range(0, 1) == 0) flaw = FLAW_NONE;
                else flaw = t_flaw'($urandom_range(FLAW_RIFF, FLAW_CUT));
                sender_steady = ($urandom_range(0, 3) == 0);
                build_file(flaw);
                send_file();
                counted += file_q.size() - trailer_len;
            end
        end

        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0) begin
            $display("wave_header_parser_core verification clean");
        end else begin
            $display("wave_header_parser_core verification failed");
        end
        $finish;
    end

endmodule
